// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the vertex transform checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define VSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define VSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_pkg
// Shared constants, register indexes and the sine table builder for the
// vertex scale and two-axis rotate block.
// ----------------------------------------------------------------------------
package vsr_pkg;

    // Field widths.
    localparam int IN_W    = 16;
    localparam int SCALE_W = 8;
    localparam int ANGLE_W = 9;
    localparam int OUT_W   = 24;
    localparam int PROD_W  = IN_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Default number of fraction bits in the sine and cosine values.
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd4;

    // Angle landmarks in whole degrees.
    localparam logic [ANGLE_W-1:0] DEG_QUARTER    = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_HALF       = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_THREE_QTR  = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_FULL       = 9'd360;
    localparam longint unsigned    DEG_HALF_TURN  = 64'd180;

    // Pi in Q51.
    localparam longint unsigned PI_Q51 = 64'd7074237752028440;

    // Output clamp limits.
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // Quarter-wave sine table, one entry per degree from 0 to 90.
    typedef longint t_sine_tab [0:90];

    // Rounded division of the n-th Taylor term by (2n)(2n+1); the divisor of
    // each of the eight terms is written out.
    function automatic longint taylor_div(input longint term, input int n);
        longint q;
        case (n)
            1: q = (term + 64'sd3) / 64'sd6;
            2: q = (term + 64'sd10) / 64'sd20;
            3: q = (term + 64'sd21) / 64'sd42;
            4: q = (term + 64'sd36) / 64'sd72;
            5: q = (term + 64'sd55) / 64'sd110;
            6: q = (term + 64'sd78) / 64'sd156;
            7: q = (term + 64'sd105) / 64'sd210;
            8: q = (term + 64'sd136) / 64'sd272;
            default: q = term;
        endcase
        return q;
    endfunction

    // Builds the quarter-wave table at elaboration: a Q30 Taylor series,
    // then rounding half up to the requested number of fraction bits.
    function automatic t_sine_tab build_sine_table(input int frac_bits);
        t_sine_tab      tab;
        longint unsigned xu;
        longint         x;
        longint         x2;
        longint         term;
        longint         sum;
        int             sh;
        sh = 30 - frac_bits;
        for (int k = 0; k <= 90; k++) begin
            xu   = (longint'(k) * PI_Q51) / DEG_HALF_TURN;
            x    = longint'((xu + (64'd1 << 20)) >> 21);
            x2   = (x * x + (64'sd1 <<< 29)) >>> 30;
            sum  = x;
            term = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2 + (64'sd1 <<< 29)) >>> 30;
                term = taylor_div(term, n);
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = (sum + (64'sd1 <<< (sh - 1))) >>> sh;
        end
        return tab;
    endfunction

endpackage

// ===== sv/vsr_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_trig
// Registered sine and cosine of the two configured angles, looked up in a
// quarter-wave table and folded into the other quadrants.
// ----------------------------------------------------------------------------
module vsr_trig #(
    parameter int TRIG_FRAC_BITS = vsr_pkg::TRIG_FRAC_BITS_DEF,
    parameter int TW             = TRIG_FRAC_BITS + 2
) (
    input  logic                              i_clk,
    input  logic [vsr_pkg::ANGLE_W-1:0]       i_angle_a,
    input  logic [vsr_pkg::ANGLE_W-1:0]       i_angle_b,
    output logic signed [TW-1:0]              o_sin_a,
    output logic signed [TW-1:0]              o_cos_a,
    output logic signed [TW-1:0]              o_sin_b,
    output logic signed [TW-1:0]              o_cos_b
);

    localparam vsr_pkg::t_sine_tab SINE_TAB = vsr_pkg::build_sine_table(TRIG_FRAC_BITS);

    logic [vsr_pkg::ANGLE_W-1:0] a_mod;
    logic [vsr_pkg::ANGLE_W-1:0] b_mod;
    logic [vsr_pkg::ANGLE_W-1:0] a_cos_deg;
    logic [vsr_pkg::ANGLE_W-1:0] b_cos_deg;
    logic signed [TW-1:0]        n_sin_a;
    logic signed [TW-1:0]        n_cos_a;
    logic signed [TW-1:0]        n_sin_b;
    logic signed [TW-1:0]        n_cos_b;
    logic signed [TW-1:0]        r_sin_a;
    logic signed [TW-1:0]        r_cos_a;
    logic signed [TW-1:0]        r_sin_b;
    logic signed [TW-1:0]        r_cos_b;

    // Sine of an angle in 0..359: fold to the first quadrant, look up, negate.
    function automatic logic signed [TW-1:0] sin_deg(input logic [vsr_pkg::ANGLE_W-1:0] deg);
        logic [vsr_pkg::ANGLE_W-1:0] idx;
        logic                        neg;
        logic signed [TW-1:0]        mag;
        if (deg <= vsr_pkg::DEG_QUARTER) begin
            idx = deg;
            neg = 1'b0;
        end else if (deg <= vsr_pkg::DEG_HALF) begin
            idx = vsr_pkg::DEG_HALF - deg;
            neg = 1'b0;
        end else if (deg <= vsr_pkg::DEG_THREE_QTR) begin
            idx = deg - vsr_pkg::DEG_HALF;
            neg = 1'b1;
        end else begin
            idx = vsr_pkg::DEG_FULL - deg;
            neg = 1'b1;
        end
        mag = TW'(SINE_TAB[idx[6:0]]);
        return neg ? -mag : mag;
    endfunction

    // Wrap the register values into 0..359 and form the cosine angles.
    always_comb begin
        a_mod = (i_angle_a >= vsr_pkg::DEG_FULL) ? (i_angle_a - vsr_pkg::DEG_FULL) : i_angle_a;
        b_mod = (i_angle_b >= vsr_pkg::DEG_FULL) ? (i_angle_b - vsr_pkg::DEG_FULL) : i_angle_b;
        a_cos_deg = (a_mod >= vsr_pkg::DEG_THREE_QTR) ? (a_mod - vsr_pkg::DEG_THREE_QTR)
                                                      : (a_mod + vsr_pkg::DEG_QUARTER);
        b_cos_deg = (b_mod >= vsr_pkg::DEG_THREE_QTR) ? (b_mod - vsr_pkg::DEG_THREE_QTR)
                                                      : (b_mod + vsr_pkg::DEG_QUARTER);
        n_sin_a = sin_deg(a_mod);
        n_cos_a = sin_deg(a_cos_deg);
        n_sin_b = sin_deg(b_mod);
        n_cos_b = sin_deg(b_cos_deg);
    end

    // The user must change angles only while the block is idle (unenforced).
    always_ff @(posedge i_clk) begin
        r_sin_a <= n_sin_a;
        r_cos_a <= n_cos_a;
        r_sin_b <= n_sin_b;
        r_cos_b <= n_cos_b;
    end

    assign o_sin_a = r_sin_a;
    assign o_cos_a = r_cos_a;
    assign o_sin_b = r_sin_b;
    assign o_cos_b = r_cos_b;

endmodule

// ===== sv/vsr_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_rot
// Three-stage planar rotation: p = u*c + v*s and q = v*c - u*s, each
// truncated toward zero after the sum. A side value rides along.
// ----------------------------------------------------------------------------
module vsr_rot #(
    parameter int TRIG_FRAC_BITS = vsr_pkg::TRIG_FRAC_BITS_DEF,
    parameter int TW             = TRIG_FRAC_BITS + 2,
    parameter int IW             = vsr_pkg::PROD_W,
    parameter int OW             = IW + 2,
    parameter int SIDE_W         = vsr_pkg::PROD_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [IW-1:0]     i_u,
    input  logic signed [IW-1:0]     i_v,
    input  logic signed [TW-1:0]     i_c,
    input  logic signed [TW-1:0]     i_s,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [OW-1:0]     o_p,
    output logic signed [OW-1:0]     o_q,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int MW = IW + TW;
    localparam int SW = MW + 1;
    localparam logic signed [SW-1:0] FRAC_MASK = SW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    logic [2:0]               r_valid;
    logic signed [MW-1:0]     r_uc;
    logic signed [MW-1:0]     r_vs;
    logic signed [MW-1:0]     r_vc;
    logic signed [MW-1:0]     r_us;
    logic signed [SW-1:0]     r_sum_p;
    logic signed [SW-1:0]     r_sum_q;
    logic signed [OW-1:0]     r_p;
    logic signed [OW-1:0]     r_q;
    logic [SIDE_W-1:0]        r_side [0:2];
    logic signed [SW-1:0]     n_adj_p;
    logic signed [SW-1:0]     n_adj_q;
    logic signed [SW-1:0]     n_shr_p;
    logic signed [SW-1:0]     n_shr_q;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Stage 1: four products.
    always_ff @(posedge i_clk) begin
        r_uc      <= MW'(i_u) * MW'(i_c);
        r_vs      <= MW'(i_v) * MW'(i_s);
        r_vc      <= MW'(i_v) * MW'(i_c);
        r_us      <= MW'(i_u) * MW'(i_s);
        r_side[0] <= i_side;
    end

    // Stage 2: the two sums.
    always_ff @(posedge i_clk) begin
        r_sum_p   <= SW'(r_uc) + SW'(r_vs);
        r_sum_q   <= SW'(r_vc) - SW'(r_us);
        r_side[1] <= r_side[0];
    end

    // Stage 3: drop the fraction bits, rounding toward zero.
    always_comb begin
        n_adj_p = r_sum_p + (r_sum_p[SW-1] ? FRAC_MASK : '0);
        n_adj_q = r_sum_q + (r_sum_q[SW-1] ? FRAC_MASK : '0);
        n_shr_p = n_adj_p >>> TRIG_FRAC_BITS;
        n_shr_q = n_adj_q >>> TRIG_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_shr_p[OW-1:0];
        r_q       <= n_shr_q[OW-1:0];
        r_side[2] <= r_side[1];
    end

    assign o_valid = r_valid[2];
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_side  = r_side[2];

endmodule

// ===== sv/vertex_scale_two_axis_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_scale_two_axis_rotate
// Scales a vertex per axis, rotates it about X by angle A, then applies a
// second rotation by angle B and clamps the result to 24-bit signed.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_x_in, i_y_in, i_z_in) is taken at a rising edge with start
//   high and busy low. busy is high only during reset and the cycle after it;
//   otherwise a new request may be issued in every cycle.
//   Each result appears on o_x_out, o_y_out, o_z_out for one cycle with
//   o_done high, in request order. Between request and result lie one
//   scaling stage, two three-stage rotation units (multiply, sum,
//   truncate) and one clamp stage.
//   Sustained throughput is one request per clock.
//   The receiver cannot hold results off, so nothing in the pipeline stalls.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//   (0 angle A, 1 angle B, 2..4 scale X, Y, Z); other indexes are ignored.
//   Write only while no request is in flight; the new angles take effect
//   once they pass the angle registers and the registered sine and cosine.
//   Reset clears the pipeline valid bits and sets angles to 0, scales to 1.
// ----------------------------------------------------------------------------
module vertex_scale_two_axis_rotate #(
    parameter int TRIG_FRAC_BITS = vsr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [vsr_pkg::IN_W-1:0]       i_x_in,
    input  logic signed [vsr_pkg::IN_W-1:0]       i_y_in,
    input  logic signed [vsr_pkg::IN_W-1:0]       i_z_in,
    input  logic                                  i_cfg_we,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [vsr_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    output logic                                  o_done,
    output logic signed [vsr_pkg::OUT_W-1:0]      o_x_out,
    output logic signed [vsr_pkg::OUT_W-1:0]      o_y_out,
    output logic signed [vsr_pkg::OUT_W-1:0]      o_z_out
);

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int PW  = vsr_pkg::PROD_W;
    localparam int AW  = PW + 2;
    localparam int BW  = AW + 2;
    localparam int OW  = vsr_pkg::OUT_W;
    localparam logic signed [BW-1:0] SAT_HI = BW'(vsr_pkg::OUT_MAX);
    localparam logic signed [BW-1:0] SAT_LO = BW'(vsr_pkg::OUT_MIN);

    logic                                r_ready;
    logic                                accept;
    logic [vsr_pkg::ANGLE_W-1:0]         r_angle_a;
    logic [vsr_pkg::ANGLE_W-1:0]         r_angle_b;
    logic signed [vsr_pkg::SCALE_W-1:0]  r_scale_x;
    logic signed [vsr_pkg::SCALE_W-1:0]  r_scale_y;
    logic signed [vsr_pkg::SCALE_W-1:0]  r_scale_z;
    logic signed [TW-1:0]                sin_a;
    logic signed [TW-1:0]                cos_a;
    logic signed [TW-1:0]                sin_b;
    logic signed [TW-1:0]                cos_b;
    logic                                r_s1_valid;
    logic signed [PW-1:0]                r_px;
    logic signed [PW-1:0]                r_py;
    logic signed [PW-1:0]                r_pz;
    logic                                rot1_valid;
    logic signed [AW-1:0]                rot1_ya;
    logic signed [AW-1:0]                rot1_za;
    logic [PW-1:0]                       rot1_px;
    logic                                rot2_valid;
    logic signed [BW-1:0]                rot2_yo;
    logic signed [BW-1:0]                rot2_xo;
    logic [AW-1:0]                       rot2_ya;
    logic                                r_done;
    logic signed [OW-1:0]                r_x_out;
    logic signed [OW-1:0]                r_y_out;
    logic signed [OW-1:0]                r_z_out;

    // Clamp a rotated value to the output range.
    function automatic logic signed [OW-1:0] sat_out(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[OW-1:0];
    endfunction

    // Ready goes high the cycle after reset is released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy   = ~r_ready;
    assign accept = start & r_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_a <= '0;
            r_angle_b <= '0;
            r_scale_x <= 8'sd1;
            r_scale_y <= 8'sd1;
            r_scale_z <= 8'sd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsr_pkg::CFG_ANGLE_A: r_angle_a <= i_cfg_wdata;
                vsr_pkg::CFG_ANGLE_B: r_angle_b <= i_cfg_wdata;
                vsr_pkg::CFG_SCALE_X: r_scale_x <= i_cfg_wdata[vsr_pkg::SCALE_W-1:0];
                vsr_pkg::CFG_SCALE_Y: r_scale_y <= i_cfg_wdata[vsr_pkg::SCALE_W-1:0];
                vsr_pkg::CFG_SCALE_Z: r_scale_z <= i_cfg_wdata[vsr_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sine and cosine of both angles.
    vsr_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .TW             (TW)
    ) u_trig (
        .i_clk     (i_clk),
        .i_angle_a (r_angle_a),
        .i_angle_b (r_angle_b),
        .o_sin_a   (sin_a),
        .o_cos_a   (cos_a),
        .o_sin_b   (sin_b),
        .o_cos_b   (cos_b)
    );

    // Stage 1: per-axis scaling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= PW'(i_x_in) * PW'(r_scale_x);
        r_py <= PW'(i_y_in) * PW'(r_scale_y);
        r_pz <= PW'(i_z_in) * PW'(r_scale_z);
    end

    // Rotation about X: ya = y*cosA + z*sinA, za = z*cosA - y*sinA.
    vsr_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .TW             (TW),
        .IW             (PW),
        .OW             (AW),
        .SIDE_W         (PW)
    ) u_rot_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_u     (r_py),
        .i_v     (r_pz),
        .i_c     (cos_a),
        .i_s     (sin_a),
        .i_side  (r_px),
        .o_valid (rot1_valid),
        .o_p     (rot1_ya),
        .o_q     (rot1_za),
        .o_side  (rot1_px)
    );

    // Second rotation: yo = za*cosB + x*sinB, xo = x*cosB - za*sinB.
    vsr_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .TW             (TW),
        .IW             (AW),
        .OW             (BW),
        .SIDE_W         (AW)
    ) u_rot_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rot1_valid),
        .i_u     (rot1_za),
        .i_v     (AW'(signed'(rot1_px))),
        .i_c     (cos_b),
        .i_s     (sin_b),
        .i_side  (rot1_ya),
        .o_valid (rot2_valid),
        .o_p     (rot2_yo),
        .o_q     (rot2_xo),
        .o_side  (rot2_ya)
    );

    // Final stage: clamp and present the result for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rot2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_out <= sat_out(rot2_xo);
        r_y_out <= sat_out(rot2_yo);
        r_z_out <= sat_out(BW'(signed'(rot2_ya)));
    end

    assign o_done  = r_done;
    assign o_x_out = r_x_out;
    assign o_y_out = r_y_out;
    assign o_z_out = r_z_out;

endmodule

// ===== sv/vsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_checker
// Port-level checks of request-to-result timing, of the zero vertex and of busy after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [vsr_pkg::IN_W-1:0]   i_x_in,
    input logic signed [vsr_pkg::IN_W-1:0]   i_y_in,
    input logic signed [vsr_pkg::IN_W-1:0]   i_z_in,
    input logic                              o_done,
    input logic signed [vsr_pkg::OUT_W-1:0]  o_x_out,
    input logic signed [vsr_pkg::OUT_W-1:0]  o_y_out,
    input logic signed [vsr_pkg::OUT_W-1:0]  o_z_out
);

    logic req_taken;
    logic zero_req;

    assign req_taken = start & ~busy;
    assign zero_req  = req_taken & (i_x_in == '0) & (i_y_in == '0) & (i_z_in == '0);

    // Every taken request is answered after the fixed latency.
    `VSR_ASSERT_IMPL(a_req_answered, i_clk, i_rst_n, req_taken,
        ##(vsr_pkg::LATENCY) o_done, "request was not answered after the pipeline latency")

    // Every result strobe belongs to a request taken one latency earlier.
    `VSR_ASSERT_IMPL(a_done_has_req, i_clk, i_rst_n, o_done,
        $past(req_taken, vsr_pkg::LATENCY), "result strobe without a matching request")

    // A zero vertex maps to the origin for any scale and angle.
    `VSR_ASSERT_IMPL(a_zero_vertex, i_clk, i_rst_n, $past(zero_req, vsr_pkg::LATENCY),
        (o_x_out == '0) && (o_y_out == '0) && (o_z_out == '0),
        "zero vertex did not map to the origin")

    // The block is not left busy after reset is released.
    `VSR_ASSERT_NEXT(a_ready_after_reset, i_clk, i_rst_n, $past(i_rst_n), !busy,
        "busy stayed high after reset")

endmodule

bind vertex_scale_two_axis_rotate vsr_checker u_vsr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_x_in  (i_x_in),
    .i_y_in  (i_y_in),
    .i_z_in  (i_z_in),
    .o_done  (o_done),
    .o_x_out (o_x_out),
    .o_y_out (o_y_out),
    .o_z_out (o_z_out)
);
